@@ design/ps2mcd_pkg.sv @@
// ----------------------------------------------------------------------------
// PS/2 mouse cursor and window drag: shared package
// Types, register indexes, reset values and helpers used by every module.
// ----------------------------------------------------------------------------
package ps2mcd_pkg;

   // Geometry defaults handed to the top level parameters.
   localparam int SCREEN_W_DEFAULT = 1280;
   localparam int SCREEN_H_DEFAULT = 1024;

   localparam int CURSOR_SIZE  = 16;
   localparam int TITLE_HEIGHT = 25;
   localparam int NUM_WINDOWS  = 3;

   // Window slots that actually exist in the register map.
   localparam int NUM_SLOTS = 3;
   localparam int HIT_SLOTS = (NUM_WINDOWS < NUM_SLOTS) ? NUM_WINDOWS : NUM_SLOTS;

   localparam logic [1:0] NO_WINDOW = 2'd3;

   // Packet header sync bit and left button bit.
   localparam int HDR_SYNC_BIT = 3;
   localparam int HDR_LEFT_BIT = 0;

   // Depth of the packet queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;

   // Configuration register map.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_VISIBLE_MASK = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN0_WIDTH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN0_HEIGHT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN1_WIDTH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN1_HEIGHT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN2_WIDTH   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN2_HEIGHT  = 3'd6;

   localparam logic [NUM_SLOTS-1:0]  VISIBLE_RESET = '0;
   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET  [NUM_SLOTS] = '{11'd450, 11'd400, 11'd300};
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET [NUM_SLOTS] = '{11'd200, 11'd250, 11'd150};

   localparam logic signed [15:0] LEFT_RESET [NUM_SLOTS] = '{16'sd450, 16'sd450, 16'sd900};
   localparam logic signed [15:0] TOP_RESET  [NUM_SLOTS] = '{16'sd400, 16'sd300, 16'sd600};

   // One assembled mouse packet.
   typedef struct packed {
      logic [7:0] header;
      logic [7:0] dx;
      logic [7:0] dy;
   } packet_type;

   // One configuration write.
   typedef struct packed {
      logic                   en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   // Adds a signed delta to a window coordinate, saturating at 16-bit signed.
   function automatic logic signed [15:0] sat16_add(logic signed [15:0] a,
                                                    logic signed [8:0]  d);
      logic signed [16:0] s;
      s = 17'(a) + 17'(d);
      if (s[16] != s[15]) begin
         sat16_add = s[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
         sat16_add = s[15:0];
      end
   endfunction

endpackage

@@ design/ps2mcd_front.sv @@
// ----------------------------------------------------------------------------
// PS/2 packet assembler
// Syncs on the header bit and collects header, X and Y bytes into packets.
// ----------------------------------------------------------------------------
module ps2mcd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [7:0]             in_byte,
   output logic                   in_ready,
   output logic                   push_valid,
   output ps2mcd_pkg::packet_type push_data,
   input  logic                   push_ready
);

   typedef enum logic [1:0] {
      SYNC,
      HAVE_HEADER,
      HAVE_DX
   } state_type;

   state_type  state_ff;
   logic [7:0] header_ff;
   logic [7:0] dx_ff;
   logic       accept;

   // A byte is only taken when a finished packet could be queued.
   assign in_ready = push_ready;
   assign accept   = in_valid && push_ready;

   assign push_valid       = accept && (state_ff == HAVE_DX);
   assign push_data.header = header_ff;
   assign push_data.dx     = dx_ff;
   assign push_data.dy     = in_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SYNC;
         header_ff <= '0;
         dx_ff     <= '0;
      end else if (accept) begin
         unique case (state_ff)
            SYNC: begin
               // Bytes without the sync bit are dropped while hunting.
               if (in_byte[ps2mcd_pkg::HDR_SYNC_BIT]) begin
                  header_ff <= in_byte;
                  state_ff  <= HAVE_HEADER;
               end
            end
            HAVE_HEADER: begin
               dx_ff    <= in_byte;
               state_ff <= HAVE_DX;
            end
            HAVE_DX: begin
               state_ff <= SYNC;
            end
            default: begin
               state_ff <= SYNC;
            end
         endcase
      end
   end

   a_push_only_on_third: assert property (@(posedge clock) disable iff (reset)
      push_valid |=> state_ff == SYNC)
      else $error("front did not resync after a packet");

endmodule

@@ design/ps2mcd_queue.sv @@
// ----------------------------------------------------------------------------
// Packet queue
// Short first-in first-out buffer between the assembler and the engine.
// ----------------------------------------------------------------------------
module ps2mcd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  ps2mcd_pkg::packet_type push_data,
   output logic                   push_ready,
   output logic                   pop_valid,
   output ps2mcd_pkg::packet_type pop_data,
   input  logic                   pop_ready
);

   localparam int DEPTH = ps2mcd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ps2mcd_pkg::packet_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a push");

endmodule

@@ design/ps2mcd_back.sv @@
// ----------------------------------------------------------------------------
// Cursor and drag engine
// Applies packets to the cursor and windows and registers one result word.
// ----------------------------------------------------------------------------
module ps2mcd_back #(
   parameter int SCREEN_W = ps2mcd_pkg::SCREEN_W_DEFAULT,
   parameter int SCREEN_H = ps2mcd_pkg::SCREEN_H_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ps2mcd_pkg::csr_write_type csr_wr,
   input  logic                      pop_valid,
   input  ps2mcd_pkg::packet_type    pop_data,
   output logic                      pop_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [10:0]               rsp_cursor_x,
   output logic [9:0]                rsp_cursor_y,
   output logic                      rsp_left_pressed,
   output logic [1:0]                rsp_drag_window,
   output logic signed [15:0]        rsp_frame_x,
   output logic signed [15:0]        rsp_frame_y,
   output logic [10:0]               rsp_frame_height,
   output logic                      rsp_drag_ended
);

   localparam int SLOTS = ps2mcd_pkg::NUM_SLOTS;
   localparam int PX_W  = $clog2(SCREEN_W);
   localparam int PY_W  = $clog2(SCREEN_H);
   localparam int PXS_W = ((PX_W > 8) ? PX_W : 8) + 2;
   localparam int PYS_W = ((PY_W > 8) ? PY_W : 8) + 2;
   localparam int CMP_W = 18;

   localparam logic signed [PXS_W-1:0] PX_MAX   = PXS_W'(SCREEN_W - ps2mcd_pkg::CURSOR_SIZE);
   localparam logic signed [PYS_W-1:0] PY_MAX   = PYS_W'(SCREEN_H - ps2mcd_pkg::CURSOR_SIZE);
   localparam logic [PX_W-1:0]         PX_RESET = PX_W'(SCREEN_W / 2);
   localparam logic [PY_W-1:0]         PY_RESET = PY_W'(SCREEN_H / 2);
   localparam logic signed [CMP_W-1:0] TITLE_H  = CMP_W'(ps2mcd_pkg::TITLE_HEIGHT);

   // Configuration registers.
   logic [SLOTS-1:0] visible_ff;
   logic [10:0]      width_ff  [SLOTS];
   logic [10:0]      height_ff [SLOTS];

   // Engine state.
   logic [PX_W-1:0]    ptr_x_ff;
   logic [PY_W-1:0]    ptr_y_ff;
   logic               prev_button_ff;
   logic [1:0]         drag_idx_ff;
   logic signed [15:0] win_left_ff [SLOTS];
   logic signed [15:0] win_top_ff  [SLOTS];

   // Result register.
   logic               rsp_valid_ff;
   logic [10:0]        cursor_x_ff;
   logic [9:0]         cursor_y_ff;
   logic               left_ff;
   logic [1:0]         drag_window_ff;
   logic signed [15:0] frame_x_ff;
   logic signed [15:0] frame_y_ff;
   logic [10:0]        frame_h_ff;
   logic               ended_ff;

   // Next values.
   logic signed [7:0]       mx;
   logic signed [7:0]       my;
   logic signed [8:0]       my_neg;
   logic                    left;
   logic signed [PXS_W-1:0] px_sum;
   logic signed [PYS_W-1:0] py_sum;
   logic [PX_W-1:0]         ptr_x_in;
   logic [PY_W-1:0]         ptr_y_in;
   logic signed [CMP_W-1:0] cmp_x;
   logic signed [CMP_W-1:0] cmp_y;
   logic [SLOTS-1:0]        hit;
   logic                    hit_found;
   logic [1:0]              hit_idx;
   logic                    start;
   logic                    moving;
   logic [1:0]              drag_idx_in;
   logic                    ended;
   logic [1:0]              report;
   logic signed [15:0]      win_left_in [SLOTS];
   logic signed [15:0]      win_top_in  [SLOTS];
   logic signed [15:0]      frame_x_in;
   logic signed [15:0]      frame_y_in;
   logic [10:0]             frame_h_in;
   logic [31:0]             px_wide;
   logic [31:0]             py_wide;
   logic                    take;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;

   always_comb begin
      mx     = signed'(pop_data.dx);
      my     = signed'(pop_data.dy);
      my_neg = -(9'(my));
      left   = pop_data.header[ps2mcd_pkg::HDR_LEFT_BIT];

      // Cursor moves with Y inverted, clamped to the screen.
      px_sum = PXS_W'(signed'({1'b0, ptr_x_ff})) + PXS_W'(mx);
      py_sum = PYS_W'(signed'({1'b0, ptr_y_ff})) - PYS_W'(my);
      if (px_sum < 0) begin
         ptr_x_in = '0;
      end else if (px_sum > PX_MAX) begin
         ptr_x_in = PX_MAX[PX_W-1:0];
      end else begin
         ptr_x_in = px_sum[PX_W-1:0];
      end
      if (py_sum < 0) begin
         ptr_y_in = '0;
      end else if (py_sum > PY_MAX) begin
         ptr_y_in = PY_MAX[PY_W-1:0];
      end else begin
         ptr_y_in = py_sum[PY_W-1:0];
      end

      // Title bar hit test on the moved cursor, lowest window first.
      cmp_x = CMP_W'(signed'({1'b0, ptr_x_in}));
      cmp_y = CMP_W'(signed'({1'b0, ptr_y_in}));
      for (int i = 0; i < SLOTS; i++) begin
         hit[i] = (i < ps2mcd_pkg::HIT_SLOTS) && visible_ff[i]
                  && (cmp_x >= CMP_W'(win_left_ff[i]))
                  && (cmp_x <= CMP_W'(win_left_ff[i])
                               + CMP_W'(signed'({1'b0, width_ff[i]})))
                  && (cmp_y >= CMP_W'(win_top_ff[i]))
                  && (cmp_y <= CMP_W'(win_top_ff[i]) + TITLE_H);
      end
      hit_found = 1'b0;
      hit_idx   = ps2mcd_pkg::NO_WINDOW;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit[i] && !hit_found) begin
            hit_found = 1'b1;
            hit_idx   = 2'(i);
         end
      end

      start = left && !prev_button_ff && (drag_idx_ff == ps2mcd_pkg::NO_WINDOW)
              && hit_found;
      if (!left) begin
         drag_idx_in = ps2mcd_pkg::NO_WINDOW;
      end else if (start) begin
         drag_idx_in = hit_idx;
      end else begin
         drag_idx_in = drag_idx_ff;
      end
      ended  = !left && (drag_idx_ff != ps2mcd_pkg::NO_WINDOW);
      moving = left && (drag_idx_in != ps2mcd_pkg::NO_WINDOW) && ((mx != 0) || (my != 0));

      for (int i = 0; i < SLOTS; i++) begin
         if (moving && (drag_idx_in == 2'(i))) begin
            win_left_in[i] = ps2mcd_pkg::sat16_add(win_left_ff[i], 9'(mx));
            win_top_in[i]  = ps2mcd_pkg::sat16_add(win_top_ff[i], my_neg);
         end else begin
            win_left_in[i] = win_left_ff[i];
            win_top_in[i]  = win_top_ff[i];
         end
      end

      // On release the outline still shows the window just dropped.
      report     = left ? drag_idx_in : (ended ? drag_idx_ff : ps2mcd_pkg::NO_WINDOW);
      frame_x_in = '0;
      frame_y_in = '0;
      frame_h_in = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (report == 2'(i)) begin
            frame_x_in = win_left_in[i];
            frame_y_in = win_top_in[i];
            frame_h_in = height_ff[i];
         end
      end

      px_wide = 32'(ptr_x_in);
      py_wide = 32'(ptr_y_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visible_ff <= ps2mcd_pkg::VISIBLE_RESET;
         for (int i = 0; i < SLOTS; i++) begin
            width_ff[i]  <= ps2mcd_pkg::WIDTH_RESET[i];
            height_ff[i] <= ps2mcd_pkg::HEIGHT_RESET[i];
         end
      end else if (csr_wr.en) begin
         unique case (csr_wr.index)
            ps2mcd_pkg::CSR_VISIBLE_MASK: visible_ff   <= csr_wr.data[SLOTS-1:0];
            ps2mcd_pkg::CSR_WIN0_WIDTH:   width_ff[0]  <= csr_wr.data;
            ps2mcd_pkg::CSR_WIN0_HEIGHT:  height_ff[0] <= csr_wr.data;
            ps2mcd_pkg::CSR_WIN1_WIDTH:   width_ff[1]  <= csr_wr.data;
            ps2mcd_pkg::CSR_WIN1_HEIGHT:  height_ff[1] <= csr_wr.data;
            ps2mcd_pkg::CSR_WIN2_WIDTH:   width_ff[2]  <= csr_wr.data;
            ps2mcd_pkg::CSR_WIN2_HEIGHT:  height_ff[2] <= csr_wr.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_x_ff       <= PX_RESET;
         ptr_y_ff       <= PY_RESET;
         prev_button_ff <= 1'b0;
         drag_idx_ff    <= ps2mcd_pkg::NO_WINDOW;
         for (int i = 0; i < SLOTS; i++) begin
            win_left_ff[i] <= ps2mcd_pkg::LEFT_RESET[i];
            win_top_ff[i]  <= ps2mcd_pkg::TOP_RESET[i];
         end
      end else if (take) begin
         ptr_x_ff       <= ptr_x_in;
         ptr_y_ff       <= ptr_y_in;
         prev_button_ff <= left;
         drag_idx_ff    <= drag_idx_in;
         for (int i = 0; i < SLOTS; i++) begin
            win_left_ff[i] <= win_left_in[i];
            win_top_ff[i]  <= win_top_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cursor_x_ff    <= px_wide[10:0];
         cursor_y_ff    <= py_wide[9:0];
         left_ff        <= left;
         drag_window_ff <= drag_idx_in;
         frame_x_ff     <= frame_x_in;
         frame_y_ff     <= frame_y_in;
         frame_h_ff     <= frame_h_in;
         ended_ff       <= ended;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_x     = cursor_x_ff;
   assign rsp_cursor_y     = cursor_y_ff;
   assign rsp_left_pressed = left_ff;
   assign rsp_drag_window  = drag_window_ff;
   assign rsp_frame_x      = frame_x_ff;
   assign rsp_frame_y      = frame_y_ff;
   assign rsp_frame_height = frame_h_ff;
   assign rsp_drag_ended   = ended_ff;

   a_end_clears_drag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ended_ff) |-> (drag_window_ff == ps2mcd_pkg::NO_WINDOW) && !left_ff)
      else $error("drag end reported with a window still held");

   a_drag_needs_button: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (drag_window_ff != ps2mcd_pkg::NO_WINDOW)) |-> left_ff)
      else $error("drag held without the left button");

   a_release_frees: assert property (@(posedge clock) disable iff (reset)
      (take && !left) |=> drag_idx_ff == ps2mcd_pkg::NO_WINDOW)
      else $error("release did not free the dragged window");

   a_idle_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !ended_ff && (drag_window_ff == ps2mcd_pkg::NO_WINDOW))
      |-> (frame_x_ff == 16'sd0) && (frame_y_ff == 16'sd0) && (frame_h_ff == '0))
      else $error("outline reported with no window");

endmodule

@@ design/ps2_mouse_cursor_window_drag.sv @@
// ----------------------------------------------------------------------------
// PS/2 mouse cursor and window drag
// Decodes 3-byte mouse packets into cursor moves and title-bar window drags.
// ----------------------------------------------------------------------------
// Raw PS/2 mouse bytes enter on the req_ channel, one word per byte, and the
// block answers each complete 3-byte packet with exactly one rsp_ word;
// header and X bytes, and bytes dropped while hunting for a header with bit 3
// set, give no word. While rsp_ready is high a new byte can be taken every
// clock cycle: the packet assembler takes one byte a cycle while the queue
// has room, a two-entry packet queue sits behind it, and the cursor and drag
// engine retires one packet a cycle into a single output register while
// that register is empty or rsp_ready is high, so the sustained rate is one
// byte per cycle. The finished packet is written into the queue when its
// last byte is taken, and its result word is then registered from there.
// Holding rsp_ready low fills the output register and then the queue, and
// req_ready drops only once the queue is full. The cursor is clamped to the
// screen minus the cursor size; a left press edge starts a drag of the first
// visible window whose title bar holds the cursor, and the dragged window
// moves without clamping, saturating at 16-bit signed. Window sizes and the
// visibility mask are written on the csr_ channel, which is always ready;
// write them only while no packet is in flight.
module ps2_mouse_cursor_window_drag #(
   parameter int SCREEN_W = ps2mcd_pkg::SCREEN_W_DEFAULT,
   parameter int SCREEN_H = ps2mcd_pkg::SCREEN_H_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Mouse byte channel.
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [7:0]                               req_mouse_byte,
   // Result channel.
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [10:0]                              rsp_cursor_x,
   output logic [9:0]                               rsp_cursor_y,
   output logic                                     rsp_left_pressed,
   output logic [1:0]                               rsp_drag_window,
   output logic signed [15:0]                       rsp_frame_x,
   output logic signed [15:0]                       rsp_frame_y,
   output logic [10:0]                              rsp_frame_height,
   output logic                                     rsp_drag_ended,
   // Configuration write channel.
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [ps2mcd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ps2mcd_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   ps2mcd_pkg::packet_type    push_data;
   ps2mcd_pkg::packet_type    pop_data;
   ps2mcd_pkg::csr_write_type csr_wr;
   logic                      push_valid;
   logic                      push_ready;
   logic                      pop_valid;
   logic                      pop_ready;

   // Register writes complete in the cycle they are presented.
   assign csr_ready    = 1'b1;
   assign csr_wr.en    = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_wdata;

   // Front end: byte sync and packet assembly.
   ps2mcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_byte    (req_mouse_byte),
      .in_ready   (req_ready),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   // Packets wait here so each side can stall on its own.
   ps2mcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // Back end: cursor, hit test, drag and the result register.
   ps2mcd_back #(
      .SCREEN_W (SCREEN_W),
      .SCREEN_H (SCREEN_H)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr           (csr_wr),
      .pop_valid        (pop_valid),
      .pop_data         (pop_data),
      .pop_ready        (pop_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cursor_x     (rsp_cursor_x),
      .rsp_cursor_y     (rsp_cursor_y),
      .rsp_left_pressed (rsp_left_pressed),
      .rsp_drag_window  (rsp_drag_window),
      .rsp_frame_x      (rsp_frame_x),
      .rsp_frame_y      (rsp_frame_y),
      .rsp_frame_height (rsp_frame_height),
      .rsp_drag_ended   (rsp_drag_ended)
   );

endmodule
